>>> rtl/snap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot checker package
// Shared types, result codes and format constants for the snapshot checker.
// ----------------------------------------------------------------------------
package snap_pkg;

  localparam int unsigned SNAP_FIFO_DEPTH = 4;

  // result kinds
  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // final status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_SMALL    = 3'd1;
  localparam logic [2:0] ST_CRC_MISMATCH = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd3;
  localparam logic [2:0] ST_BAD_VERSION  = 3'd4;

  // image format
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [4:0]  HDR_LEN    = 5'd22;
  localparam logic [4:0]  VER_LO_POS = 5'd4;
  localparam logic [4:0]  VER_HI_POS = 5'd5;
  localparam logic [4:0]  CNT_POS    = 5'd14;
  localparam logic [2:0]  TAIL_LEN   = 3'd4;
  localparam logic [3:0][7:0] MAGIC  = {8'h53, 8'h53, 8'h56, 8'h4B}; // "KVSS"

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_KLEN,
    PH_KDATA,
    PH_VLEN,
    PH_VDATA,
    PH_DONE
  } snap_phase_t;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       image_end;
  } snap_in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  payload_byte;
    logic        field_end;
    logic [2:0]  check_status;
    logic [63:0] records_done;
    logic        final_item;
  } snap_out_t;

  // everything one input byte produces, handed from front to back
  typedef struct packed {
    logic        has_data;
    logic        data_is_value;
    logic [7:0]  data_byte;
    logic        data_end;
    logic        has_rec;
    logic        has_status;
    logic [2:0]  status;
    logic [63:0] recs;
  } snap_bundle_t;

endpackage
`default_nettype wire

>>> rtl/snap_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot checker front end
// Tail delay, CRC-32 and header/record parser; one input byte per cycle while in_accept is high.
// ----------------------------------------------------------------------------
module snap_front import snap_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_accept,
  input  wire snap_in_t     in_item,
  input  wire logic [15:0]  exp_version,
  output logic              bundle_valid,
  output snap_bundle_t      bundle
);

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

  logic [31:0]      crc_r, crc_upd, crc_nxt;
  logic [3:0][7:0]  tail_r, tail_upd, tail_nxt;
  logic [2:0]       fill_r, fill_upd, fill_nxt;
  logic [4:0]       hpos_r, hpos_upd, hpos_nxt;
  snap_phase_t      phase_r, phase_upd, phase_nxt;
  logic [1:0]       lidx_r, lidx_upd, lidx_nxt;
  logic [31:0]      frem_r, frem_upd, frem_nxt;
  logic [63:0]      target_r, target_upd, target_nxt;
  logic [63:0]      seen_r, seen_upd, seen_nxt;
  logic [1:0]       flags_r, flags_upd, flags_nxt;
  logic [7:0]       verlo_r, verlo_upd, verlo_nxt;

  logic        rel;
  logic [7:0]  rel_byte;
  logic        last;
  logic        field_last;
  logic        len_done;
  logic [31:0] frem_len;
  logic [63:0] seen_inc;
  logic        seen_hit;
  logic [2:0]  lane;
  logic        data_emit;
  logic        rec_finish;
  logic [2:0]  status;

  assign rel        = (fill_r == TAIL_LEN);
  assign rel_byte   = tail_r[0];
  assign last       = in_item.image_end;
  assign field_last = (frem_r == 32'd1);
  assign len_done   = (lidx_r == 2'd3);
  assign frem_len   = frem_r | ({24'h0, rel_byte} << {lidx_r, 3'b000});
  assign seen_inc   = seen_r + 64'd1;
  assign seen_hit   = (seen_inc == target_r);
  assign lane       = 3'(hpos_r - CNT_POS);
  assign data_emit  = rel && (phase_r == PH_KDATA || phase_r == PH_VDATA);
  assign rec_finish = rel && ((phase_r == PH_VLEN && len_done && frem_len == 32'd0) ||
                              (phase_r == PH_VDATA && field_last));

  // next state: apply one byte, then clear everything on the final byte
  always_comb begin
    crc_upd    = crc_r;
    tail_upd   = tail_r;
    fill_upd   = fill_r;
    hpos_upd   = hpos_r;
    phase_upd  = phase_r;
    lidx_upd   = lidx_r;
    frem_upd   = frem_r;
    target_upd = target_r;
    seen_upd   = seen_r;
    flags_upd  = flags_r;
    verlo_upd  = verlo_r;
    if (rel) begin
      crc_upd     = crc_byte(crc_r, rel_byte);
      tail_upd[0] = tail_r[1];
      tail_upd[1] = tail_r[2];
      tail_upd[2] = tail_r[3];
      tail_upd[3] = in_item.image_byte;
      case (phase_r)
        PH_HEADER: begin
          if (hpos_r < VER_LO_POS) begin
            if (rel_byte != MAGIC[hpos_r[1:0]]) flags_upd[0] = 1'b1;
          end else if (hpos_r == VER_LO_POS) begin
            verlo_upd = rel_byte;
          end else if (hpos_r == VER_HI_POS) begin
            if ({rel_byte, verlo_r} != exp_version) flags_upd[1] = 1'b1;
          end else if (hpos_r >= CNT_POS) begin
            target_upd[{lane, 3'b000} +: 8] = target_r[{lane, 3'b000} +: 8] | rel_byte;
          end
          hpos_upd = hpos_r + 5'd1;
          if (hpos_upd == HDR_LEN) begin
            phase_upd = (target_upd == 64'd0) ? PH_DONE : PH_KLEN;
          end
        end
        PH_KLEN, PH_VLEN: begin
          frem_upd = frem_len;
          lidx_upd = lidx_r + 2'd1;
          if (len_done) begin
            if (phase_r == PH_KLEN) begin
              phase_upd = (frem_len == 32'd0) ? PH_VLEN : PH_KDATA;
            end else if (frem_len == 32'd0) begin
              seen_upd  = seen_inc;
              phase_upd = seen_hit ? PH_DONE : PH_KLEN;
            end else begin
              phase_upd = PH_VDATA;
            end
          end
        end
        PH_KDATA: begin
          frem_upd = frem_r - 32'd1;
          if (field_last) phase_upd = PH_VLEN;
        end
        PH_VDATA: begin
          frem_upd = frem_r - 32'd1;
          if (field_last) begin
            seen_upd  = seen_inc;
            phase_upd = seen_hit ? PH_DONE : PH_KLEN;
          end
        end
        default: begin
        end
      endcase
    end else begin
      tail_upd[fill_r[1:0]] = in_item.image_byte;
      fill_upd = fill_r + 3'd1;
    end

    crc_nxt    = crc_upd;
    tail_nxt   = tail_upd;
    fill_nxt   = fill_upd;
    hpos_nxt   = hpos_upd;
    phase_nxt  = phase_upd;
    lidx_nxt   = lidx_upd;
    frem_nxt   = frem_upd;
    target_nxt = target_upd;
    seen_nxt   = seen_upd;
    flags_nxt  = flags_upd;
    verlo_nxt  = verlo_upd;
    if (last) begin
      crc_nxt    = CRC_INIT;
      tail_nxt   = '0;
      fill_nxt   = '0;
      hpos_nxt   = '0;
      phase_nxt  = PH_HEADER;
      lidx_nxt   = '0;
      frem_nxt   = '0;
      target_nxt = '0;
      seen_nxt   = '0;
      flags_nxt  = '0;
      verlo_nxt  = '0;
    end
  end

  // outputs: what this byte hands to the back end
  always_comb begin
    if (fill_upd != TAIL_LEN || hpos_upd != HDR_LEN) begin
      status = ST_TOO_SMALL;
    end else if (tail_upd != ~crc_upd) begin
      status = ST_CRC_MISMATCH;
    end else if (flags_upd[0]) begin
      status = ST_BAD_MAGIC;
    end else if (flags_upd[1]) begin
      status = ST_BAD_VERSION;
    end else begin
      status = ST_OK;
    end
    bundle               = '0;
    bundle.has_data      = data_emit;
    bundle.data_is_value = (phase_r == PH_VDATA);
    bundle.data_byte     = rel_byte;
    bundle.data_end      = field_last;
    bundle.has_rec       = rec_finish;
    bundle.has_status    = last;
    bundle.status        = status;
    bundle.recs          = (status == ST_OK) ? seen_upd : 64'd0;
    bundle_valid         = in_accept && (data_emit || rec_finish || last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      tail_r   <= '0;
      fill_r   <= '0;
      hpos_r   <= '0;
      phase_r  <= PH_HEADER;
      lidx_r   <= '0;
      frem_r   <= '0;
      target_r <= '0;
      seen_r   <= '0;
      flags_r  <= '0;
      verlo_r  <= '0;
    end else if (in_accept) begin
      crc_r    <= crc_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      hpos_r   <= hpos_nxt;
      phase_r  <= phase_nxt;
      lidx_r   <= lidx_nxt;
      frem_r   <= frem_nxt;
      target_r <= target_nxt;
      seen_r   <= seen_nxt;
      flags_r  <= flags_nxt;
      verlo_r  <= verlo_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/snap_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot checker bundle queue
// Short queue that decouples the parser front end from the result back end.
// ----------------------------------------------------------------------------
module snap_fifo import snap_pkg::*; #(
  parameter int unsigned DEPTH = SNAP_FIFO_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire snap_bundle_t wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output snap_bundle_t      rd_data,
  output logic              empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  snap_bundle_t     slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/snap_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot checker back end
// Unpacks each bundle into its results and drives the output register.
// ----------------------------------------------------------------------------
module snap_back import snap_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire snap_bundle_t q_data,
  input  wire logic         q_empty,
  output logic              q_rd,
  input  wire logic         out_pop,
  output snap_out_t         out_item,
  output logic              out_empty
);

  snap_bundle_t work_r, work_nxt, work_left;
  snap_out_t    out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;
  logic         take;
  logic         left_any;

  assign out_free = !out_valid_r || out_pop;
  assign take     = out_free && (work_r.has_data || work_r.has_rec || work_r.has_status);

  always_comb begin
    out_nxt   = '0;
    work_left = work_r;
    // emit in order: data byte, record completion, status
    if (work_r.has_data) begin
      out_nxt.item_kind    = work_r.data_is_value ? KIND_VALUE : KIND_KEY;
      out_nxt.payload_byte = work_r.data_byte;
      out_nxt.field_end    = work_r.data_end;
      work_left.has_data   = !take;
    end else if (work_r.has_rec) begin
      out_nxt.item_kind    = KIND_RECORD;
      work_left.has_rec    = !take;
    end else begin
      out_nxt.item_kind    = KIND_STATUS;
      out_nxt.check_status = work_r.status;
      out_nxt.records_done = work_r.recs;
      out_nxt.final_item   = 1'b1;
      work_left.has_status = !take && work_r.has_status;
    end
    left_any = work_left.has_data || work_left.has_rec || work_left.has_status;
    q_rd     = !left_any && !q_empty;
    work_nxt = q_rd ? q_data : work_left;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      work_r      <= work_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_item  = out_r;
  assign out_empty = !out_valid_r;

endmodule
`default_nettype wire

>>> rtl/snapshot_stream_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot stream checker
// Checks a key/value snapshot image byte by byte and streams out its records.
//
// Input queue side: in_item carries one image byte and an end flag; it is
// taken when push is high and full is low. One byte per cycle is accepted as
// long as the bundle queue (FIFO_DEPTH entries) has room.
// Result queue side: the oldest result sits on out_item while empty is low
// and is taken when pop is high. Each byte gives up to three results (key or
// value byte, record complete, final status), delivered one per cycle while
// pop is high; a byte holds the output until all of its results are taken.
// Each result passes the bundle queue, the work register and out register.
// The last four bytes of an image are the stored CRC; payload bytes come out
// four bytes late, and key/value bytes go out before the image is checked.
// cfg_wr_en/cfg_wr_data write the expected header version (reset 1).
// Reset clears the parser, CRC and queues; nothing is lost when the receiver
// stalls, the queue fills and full backs up the input.
// ----------------------------------------------------------------------------
module snapshot_stream_checker import snap_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = SNAP_FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire snap_in_t    in_item,
  output logic             empty,
  input  wire logic        pop,
  output snap_out_t        out_item,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic [15:0]  exp_version_r;
  logic         in_accept;
  logic         bundle_valid;
  snap_bundle_t bundle;
  logic         q_rd;
  logic         q_empty;
  snap_bundle_t q_data;
  logic         out_pop;

  assign in_accept = push && !full;
  assign out_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= 16'd1;
    end else if (cfg_wr_en) begin
      exp_version_r <= cfg_wr_data;
    end
  end

  snap_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_item      (in_item),
    .exp_version  (exp_version_r),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  snap_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bundle_valid),
    .wr_data (bundle),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  snap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .out_empty (empty)
  );

endmodule
`default_nettype wire

>>> rtl/snap_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Snapshot checker port assertions
// Watches the result side of the snapshot checker over time, and both queue flags after reset.
// ----------------------------------------------------------------------------
module snap_checker import snap_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      full,
  input wire logic      empty,
  input wire logic      pop,
  input wire snap_out_t out_item
);

  // queues come out of reset empty and open
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  // only the status result closes an image
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.final_item == (out_item.item_kind == KIND_STATUS)))
    else $error("final flag and status kind disagree");

  // record count only on an ok status
  a_recs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_item.records_done != 64'd0 |->
      out_item.final_item && out_item.check_status == ST_OK)
    else $error("record count outside ok status");

  // record and status results carry no byte
  a_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_item.item_kind == KIND_RECORD || out_item.item_kind == KIND_STATUS) |->
      out_item.payload_byte == 8'd0 && !out_item.field_end)
    else $error("byte fields set on a non-data result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind snapshot_stream_checker snap_checker u_snap_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
`default_nettype wire

>>> sim/snapshot_stream_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapshot stream checker testbench
// Streams whole snapshot images into the checker (minimal, record-bearing,
// truncated, corrupted and random-noise images) under random stalls on both
// sides. A predictor tracks the delay line, CRC and record parser per byte and
// every result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module snapshot_stream_checker_tb;
  import snap_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  snap_in_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  snap_out_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  // stimulus and expected results
  snap_in_t    byte_q[$];
  snap_out_t   due_results[$];
  int unsigned total_queued = 0;
  logic        byte_taken = 1'b0;
  logic        calm = 1'b0;
  int unsigned send_hold = 0;
  int unsigned take_hold = 0;

  // predictor state
  logic [15:0] cfg_version = 16'd1;
  logic [31:0] crc_run;
  logic [7:0]  held [4];
  int unsigned held_n;
  int unsigned hdr_seen;
  snap_phase_t phase;
  int unsigned len_bit;
  logic [31:0] field_left;
  logic [63:0] rec_goal;
  logic [63:0] rec_count;
  logic        magic_bad;
  logic        version_bad;
  logic [15:0] version_got;

  // run statistics
  int unsigned fail_count = 0;
  int unsigned bytes_in = 0;
  int unsigned results_seen = 0;
  int unsigned status_seen [8];

  snapshot_stream_checker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  task automatic clear_image();
    crc_run = CRC_INIT;
    for (int i = 0; i < 4; i++) begin
      held[i] = 8'h00;
    end
    held_n = 0;
    hdr_seen = 0;
    phase = PH_HEADER;
    len_bit = 0;
    field_left = '0;
    rec_goal = '0;
    rec_count = '0;
    magic_bad = 1'b0;
    version_bad = 1'b0;
    version_got = '0;
  endtask

  task automatic queue_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic fend, input logic [2:0] st,
                              input logic [63:0] recs, input logic fin);
    snap_out_t r;
    r.item_kind = kind;
    r.payload_byte = data;
    r.field_end = fend;
    r.check_status = st;
    r.records_done = recs;
    r.final_item = fin;
    due_results.push_back(r);
  endtask

  task automatic close_record();
    queue_result(KIND_RECORD, 8'h00, 1'b0, ST_OK, 64'd0, 1'b0);
    rec_count++;
    if (rec_count == rec_goal) begin
      phase = PH_DONE;
    end else begin
      phase = PH_KLEN;
    end
  endtask

  // Advance the image state by one byte and queue whatever it produces.
  task automatic predict_byte(input snap_in_t it);
    logic [7:0]  b;
    logic [31:0] stored;
    logic [2:0]  st;
    logic [63:0] recs;
    if (held_n == 4) begin
      b = held[0];
      held[0] = held[1];
      held[1] = held[2];
      held[2] = held[3];
      held[3] = it.image_byte;
      crc_run = crc_step(crc_run, b);
      case (phase)
        PH_HEADER: begin
          if (hdr_seen < VER_LO_POS) begin
            if (b != MAGIC[hdr_seen]) magic_bad = 1'b1;
          end else if (hdr_seen == VER_LO_POS) begin
            version_got = {8'h00, b};
          end else if (hdr_seen == VER_HI_POS) begin
            version_got[15:8] = b;
            if (version_got != cfg_version) version_bad = 1'b1;
          end else if (hdr_seen >= CNT_POS) begin
            rec_goal[8 * (hdr_seen - CNT_POS) +: 8] = b;
          end
          hdr_seen++;
          if (hdr_seen == HDR_LEN) begin
            if (rec_goal == 0) begin
              phase = PH_DONE;
            end else begin
              phase = PH_KLEN;
            end
          end
        end
        PH_KLEN, PH_VLEN: begin
          field_left[len_bit +: 8] = b;
          len_bit += 8;
          if (len_bit == 32) begin
            len_bit = 0;
            if (phase == PH_KLEN) begin
              if (field_left == 0) begin
                phase = PH_VLEN;
              end else begin
                phase = PH_KDATA;
              end
            end else if (field_left == 0) begin
              close_record();
            end else begin
              phase = PH_VDATA;
            end
          end
        end
        PH_KDATA, PH_VDATA: begin
          field_left--;
          queue_result((phase == PH_KDATA) ? KIND_KEY : KIND_VALUE, b, field_left == 0,
                       ST_OK, 64'd0, 1'b0);
          if (field_left == 0) begin
            if (phase == PH_KDATA) begin
              phase = PH_VLEN;
            end else begin
              close_record();
            end
          end
        end
        default: begin
          // count reached: drop the byte
        end
      endcase
    end else begin
      held[held_n] = it.image_byte;
      held_n++;
    end

    if (it.image_end) begin
      stored = {held[3], held[2], held[1], held[0]};
      recs = '0;
      if (held_n < 4 || hdr_seen < HDR_LEN) begin
        st = ST_TOO_SMALL;
      end else if (stored != ~crc_run) begin
        st = ST_CRC_MISMATCH;
      end else if (magic_bad) begin
        st = ST_BAD_MAGIC;
      end else if (version_bad) begin
        st = ST_BAD_VERSION;
      end else begin
        st = ST_OK;
        recs = rec_count;
      end
      queue_result(KIND_STATUS, 8'h00, 1'b0, st, recs, 1'b1);
      clear_image();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    snap_in_t it;
    it.image_byte = b;
    it.image_end = last;
    byte_q.push_back(it);
    total_queued++;
  endtask

  task automatic add_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      queue_byte(8'($urandom), i == n - 1);
    end
  endtask

  // Build one image: header, nrec records with field lengths in
  // [min_len, max_len], an optional runaway key length, then the CRC.
  task automatic add_image(input logic [15:0] ver, input logic [63:0] count,
                           input int unsigned nrec, input int unsigned min_len,
                           input int unsigned max_len, input int unsigned cut,
                           input bit bad_magic, input bit bad_crc, input bit long_key);
    logic [7:0]  img[$];
    logic [31:0] crc;
    logic [31:0] flen;
    int unsigned i;
    int unsigned r;
    for (i = 0; i < 4; i++) img.push_back(MAGIC[i]);
    img.push_back(ver[7:0]);
    img.push_back(ver[15:8]);
    for (i = 0; i < 8; i++) img.push_back(8'($urandom));
    for (i = 0; i < 8; i++) img.push_back(count[8 * i +: 8]);
    for (r = 0; r < 2 * nrec; r++) begin
      flen = $urandom_range(min_len, max_len);
      for (i = 0; i < 4; i++) img.push_back(flen[8 * i +: 8]);
      repeat (flen) img.push_back(8'($urandom));
    end
    if (long_key) begin
      flen = $urandom | 32'h0100_0000;
      for (i = 0; i < 4; i++) img.push_back(flen[8 * i +: 8]);
      repeat ($urandom_range(1, 3)) img.push_back(8'($urandom));
    end
    if (bad_magic) img[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    repeat (cut) begin
      if (img.size() > 0) void'(img.pop_back());
    end
    crc = CRC_INIT;
    foreach (img[j]) crc = crc_step(crc, img[j]);
    crc = ~crc;
    if (bad_crc) crc ^= 32'(1) << $urandom_range(0, 31);
    foreach (img[j]) queue_byte(img[j], 1'b0);
    for (i = 0; i < 4; i++) queue_byte(crc[8 * i +: 8], i == 3);
  endtask

  task automatic random_images(input int unsigned nbytes);
    int unsigned goal;
    int unsigned nrec;
    goal = total_queued + nbytes;
    while (total_queued < goal) begin
      nrec = $urandom_range(0, 3);
      case ($urandom_range(0, 11))
        0: add_noise($urandom_range(1, 30));
        1: add_image(cfg_version, nrec, nrec, 0, 3, 0, 1'b0, 1'b1, 1'b0);
        2: add_image(cfg_version, nrec, nrec, 0, 3, 0, 1'b1, 1'b0, 1'b0);
        3: add_image(cfg_version ^ (16'd1 << $urandom_range(0, 15)), nrec, nrec, 0, 3, 0,
                     1'b0, 1'b0, 1'b0);
        4: add_image(cfg_version, {32'($urandom), 32'($urandom)}, nrec, 0, 3,
                     $urandom_range(0, 6), 1'b0, 1'b0, 1'b0);
        5: add_image(16'($urandom), nrec, nrec, 0, 3, 0, 1'b0, 1'b0, 1'b0);
        6: add_image(cfg_version, nrec + 1, nrec, 0, 3, $urandom_range(0, 2), 1'b0, 1'b0,
                     1'b1);
        default: add_image(cfg_version, $urandom_range(0, nrec), nrec, 0, 3, 0, 1'b0, 1'b0,
                           $urandom_range(0, 3) == 0);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || push || due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_version(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_version = v;
  endtask

  // input driver: hold the item until taken, then advance or idle a burst
  always @(negedge clk) begin
    if (rst_n) begin
      if (!push || byte_taken) begin
        if (send_hold != 0) begin
          push <= 1'b0;
          send_hold <= send_hold - 1;
        end else if (byte_q.size() != 0) begin
          push <= 1'b1;
          in_item <= byte_q.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) send_hold <= $urandom_range(1, 19);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side: pop with random stall bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (take_hold != 0) begin
        pop <= 1'b0;
        take_hold <= take_hold - 1;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) take_hold <= $urandom_range(1, 19);
      end
    end
  end

  always @(posedge clk) begin : result_watch
    snap_out_t want;
    byte_taken <= rst_n && push && !full;
    if (rst_n && push && !full) begin
      bytes_in++;
      predict_byte(in_item);
    end
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%0h", out_item));
      end else begin
        want = due_results.pop_front();
        check_field("item_kind", out_item.item_kind, want.item_kind);
        check_field("payload_byte", out_item.payload_byte, want.payload_byte);
        check_field("field_end", out_item.field_end, want.field_end);
        check_field("check_status", out_item.check_status, want.check_status);
        check_field("records_done", out_item.records_done, want.records_done);
        check_field("final_item", out_item.final_item, want.final_item);
        if (want.item_kind == KIND_STATUS) status_seen[want.check_status]++;
      end
    end
  end

  initial begin
    clear_image();
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed images at the reset version
    add_noise(1);
    add_noise(25);
    // three empty records, then a runaway key length cut off by the end
    add_image(16'd1, 64'hFFFF_FFFF_FFFF_FFFF, 3, 0, 0, 0, 1'b0, 1'b0, 1'b1);
    // count of two with a third record left over
    add_image(16'd1, 64'd2, 3, 1, 4, 0, 1'b0, 1'b0, 1'b0);
    add_image(16'd1, 64'd0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    add_image(16'd2, 64'd0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b0);
    add_image(16'h8001, 64'd0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0);
    add_image(16'd0, 64'd0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
    // record cut inside its value
    add_image(16'd1, 64'd1, 1, 2, 3, 2, 1'b0, 1'b0, 1'b0);
    wait_drained();

    write_version(16'hFFFF);
    random_images(1);
    wait_drained();
    write_version(16'h0000);
    random_images(1);
    wait_drained();
    write_version(16'($urandom));
    random_images(1);
    wait_drained();
    // last stretch runs with no idling on either side
    calm = 1'b1;
    write_version(16'd1);
    random_images(20);
    wait_drained();
    repeat (8) @(negedge clk);

    $display("summary: %0d bytes, %0d results checked, versions up to 0xffff exercised",
             bytes_in, results_seen);
    $display("summary: status ok %0d, too small %0d, crc %0d, magic %0d, version %0d",
             status_seen[ST_OK], status_seen[ST_TOO_SMALL], status_seen[ST_CRC_MISMATCH],
             status_seen[ST_BAD_MAGIC], status_seen[ST_BAD_VERSION]);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
